// ===== rtl/ryuv_pkg.sv =====
// Shared types, constants and coefficient tables for the RGB to YUV 4:2:0 converter.
// No dependencies; every other rtl file imports this package.
package ryuv_pkg;

   localparam int MAX_WIDTH = 4096;
   localparam int COL_W     = $clog2(MAX_WIDTH);
   localparam int WIDTH_W   = 13;
   localparam int CSR_IDX_W = 2;
   localparam int COEF_W    = 9;
   localparam int PROD_W    = 2 * COEF_W;
   localparam int SUM_W     = PROD_W + 1;
   localparam int RES_W     = 12;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_MATRIX = 2'd0,
      CSR_RANGE  = 2'd1,
      CSR_WIDTH  = 2'd2
   } csr_index_type;

   localparam logic [WIDTH_W-1:0] DEFAULT_WIDTH = WIDTH_W'(1920);

   localparam logic signed [RES_W-1:0] LIMITED_ZERO       = RES_W'(16);
   localparam logic signed [RES_W-1:0] LIMITED_LUMA_MAX   = RES_W'(235);
   localparam logic signed [RES_W-1:0] LIMITED_CHROMA_MAX = RES_W'(240);
   localparam logic signed [RES_W-1:0] FULL_MAX           = RES_W'(255);
   localparam logic signed [RES_W-1:0] CHROMA_OFFSET      = RES_W'(128);
   localparam logic [7:0]              CHROMA_NEUTRAL     = 8'd128;

   // [matrix][full][row][colour]: matrix 0 BT.601, 1 BT.709; full 0 limited, 1 full
   localparam logic signed [COEF_W-1:0] COEF_TABLE [2][2][3][3] = '{
      '{
         '{'{9'sd66, 9'sd129, 9'sd25}, '{-9'sd38, -9'sd74, 9'sd112},
           '{9'sd112, -9'sd94, -9'sd18}},
         '{'{9'sd76, 9'sd150, 9'sd29}, '{-9'sd43, -9'sd85, 9'sd128},
           '{9'sd128, -9'sd107, -9'sd21}}
      },
      '{
         '{'{9'sd47, 9'sd157, 9'sd16}, '{-9'sd26, -9'sd86, 9'sd112},
           '{9'sd112, -9'sd102, -9'sd10}},
         '{'{9'sd54, 9'sd183, 9'sd18}, '{-9'sd29, -9'sd99, 9'sd128},
           '{9'sd128, -9'sd116, -9'sd12}}
      }
   };

   typedef struct packed {
      logic               matrix_select;
      logic               range_mode;
      logic [WIDTH_W-1:0] image_width;
   } cfg_type;

   typedef struct packed {
      logic [7:0] blue;
      logic [7:0] green;
      logic [7:0] red;
   } pixel_type;

   typedef struct packed {
      pixel_type pixel;
      logic      chroma_valid;
   } stage_type;

endpackage

// ===== rtl/ryuv_csr.sv =====
// Configuration registers: matrix select, range mode and image width.
// Depends on ryuv_pkg.
module ryuv_csr (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [ryuv_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [ryuv_pkg::WIDTH_W-1:0]    csr_data,
   output ryuv_pkg::cfg_type               cfg
);
   import ryuv_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_MATRIX: cfg_in.matrix_select = csr_data[0];
            CSR_RANGE:  cfg_in.range_mode    = csr_data[0];
            CSR_WIDTH:  cfg_in.image_width   = csr_data;
            default:    cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.matrix_select <= 1'b0;
         cfg_ff.range_mode    <= 1'b0;
         cfg_ff.image_width   <= DEFAULT_WIDTH;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

// ===== rtl/ryuv_in_stage.sv =====
// Input register with column and row parity tracking for chroma siting.
// Depends on ryuv_pkg.
module ryuv_in_stage (
   input  logic                          clock,
   input  logic                          reset,
   input  logic [ryuv_pkg::WIDTH_W-1:0]  image_width,
   input  logic                          in_valid,
   output logic                          in_ready,
   input  ryuv_pkg::pixel_type           in_pixel,
   input  logic                          in_frame_start,
   output logic                          out_valid,
   input  logic                          out_ready,
   output ryuv_pkg::stage_type           out_stage
);
   import ryuv_pkg::*;

   logic               valid_ff;
   logic               valid_in;
   stage_type          stage_ff;
   logic [COL_W-1:0]   column_ff;
   logic [COL_W-1:0]   column_in;
   logic               row_odd_ff;
   logic               row_odd_in;
   logic [COL_W-1:0]   column_cur;
   logic               row_cur;
   logic [WIDTH_W-1:0] width_eff;
   logic               take;
   logic               wrap;

   assign in_ready  = !valid_ff || out_ready;
   assign take      = in_valid && in_ready;
   assign out_valid = valid_ff;
   assign out_stage = stage_ff;

   always_comb begin
      if (image_width == '0) begin
         width_eff = WIDTH_W'(1);
      end else if (image_width > WIDTH_W'(MAX_WIDTH)) begin
         width_eff = WIDTH_W'(MAX_WIDTH);
      end else begin
         width_eff = image_width;
      end
   end

   always_comb begin
      column_cur = in_frame_start ? '0 : column_ff;
      row_cur    = in_frame_start ? 1'b0 : row_odd_ff;
      wrap       = (WIDTH_W'(column_cur) + WIDTH_W'(1)) >= width_eff;
      column_in  = column_ff;
      row_odd_in = row_odd_ff;
      valid_in   = valid_ff;
      if (take) begin
         column_in  = wrap ? '0 : column_cur + COL_W'(1);
         row_odd_in = wrap ? !row_cur : row_cur;
         valid_in   = 1'b1;
      end else if (out_ready) begin
         valid_in   = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff   <= 1'b0;
         column_ff  <= '0;
         row_odd_ff <= 1'b0;
      end else begin
         valid_ff   <= valid_in;
         column_ff  <= column_in;
         row_odd_ff <= row_odd_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         stage_ff.pixel        <= in_pixel;
         stage_ff.chroma_valid <= !column_cur[0] && !row_cur;
      end
   end

endmodule

// ===== rtl/ryuv_matrix_stage.sv =====
// Color matrix, floor shift, offset and clamp, then the result register.
// Depends on ryuv_pkg.
module ryuv_matrix_stage (
   input  logic                 clock,
   input  logic                 reset,
   input  ryuv_pkg::cfg_type    cfg,
   input  logic                 in_valid,
   output logic                 in_ready,
   input  ryuv_pkg::stage_type  in_stage,
   output logic                 out_valid,
   input  logic                 out_ready,
   output logic [7:0]           out_luma,
   output logic [7:0]           out_cb,
   output logic [7:0]           out_cr,
   output logic                 out_chroma_valid
);
   import ryuv_pkg::*;

   logic                     valid_ff;
   logic                     valid_in;
   logic                     take;
   logic [7:0]               luma_ff;
   logic [7:0]               cb_ff;
   logic [7:0]               cr_ff;
   logic                     chroma_ff;
   logic [7:0]               luma_in;
   logic [7:0]               cb_in;
   logic [7:0]               cr_in;
   logic signed [COEF_W-1:0] px [3];
   logic signed [SUM_W-1:0]  sum [3];
   logic signed [RES_W-1:0]  val [3];
   logic signed [RES_W-1:0]  lo;
   logic signed [RES_W-1:0]  luma_hi;
   logic signed [RES_W-1:0]  chroma_hi;
   logic signed [RES_W-1:0]  luma_off;
   logic [7:0]               clamped [3];

   assign in_ready = !valid_ff || out_ready;
   assign take     = in_valid && in_ready;

   assign px[0] = $signed({1'b0, in_stage.pixel.red});
   assign px[1] = $signed({1'b0, in_stage.pixel.green});
   assign px[2] = $signed({1'b0, in_stage.pixel.blue});

   assign lo        = cfg.range_mode ? '0 : LIMITED_ZERO;
   assign luma_hi   = cfg.range_mode ? FULL_MAX : LIMITED_LUMA_MAX;
   assign chroma_hi = cfg.range_mode ? FULL_MAX : LIMITED_CHROMA_MAX;
   assign luma_off  = lo;

   always_comb begin
      logic signed [PROD_W-1:0] prod [3];
      logic signed [RES_W-1:0]  hi;
      for (int r = 0; r < 3; r++) begin
         for (int c = 0; c < 3; c++) begin
            prod[c] = px[c] * COEF_TABLE[cfg.matrix_select][cfg.range_mode][r][c];
         end
         sum[r] = SUM_W'(prod[0]) + SUM_W'(prod[1]) + SUM_W'(prod[2]);
         val[r] = RES_W'($signed(sum[r][SUM_W-1:8]))
                  + ((r == 0) ? luma_off : CHROMA_OFFSET);
         hi = (r == 0) ? luma_hi : chroma_hi;
         if (val[r] < lo) begin
            clamped[r] = lo[7:0];
         end else if (val[r] > hi) begin
            clamped[r] = hi[7:0];
         end else begin
            clamped[r] = val[r][7:0];
         end
      end
   end

   assign luma_in = clamped[0];
   assign cb_in   = in_stage.chroma_valid ? clamped[1] : CHROMA_NEUTRAL;
   assign cr_in   = in_stage.chroma_valid ? clamped[2] : CHROMA_NEUTRAL;

   always_comb begin
      valid_in = valid_ff;
      if (take) begin
         valid_in = 1'b1;
      end else if (out_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         luma_ff   <= luma_in;
         cb_ff     <= cb_in;
         cr_ff     <= cr_in;
         chroma_ff <= in_stage.chroma_valid;
      end
   end

   assign out_valid        = valid_ff;
   assign out_luma         = luma_ff;
   assign out_cb           = cb_ff;
   assign out_cr           = cr_ff;
   assign out_chroma_valid = chroma_ff;

endmodule

// ===== rtl/rgb_to_yuv420_converter.sv =====
// Top level of the RGB to YUV 4:2:0 converter: config registers, input stage, matrix stage.
// Depends on ryuv_pkg, ryuv_csr, ryuv_in_stage and ryuv_matrix_stage.
//
// Converts one RGB pixel per beat to Y, with Cb/Cr point-sampled at even columns of even
// rows (BT.601 or BT.709, full or limited range). Throughput is one pixel per clock while
// rsp_tready stays high; a pixel passes the input register and then the result register
// around the matrix logic on its way to the result side. Column and row parity restart on a
// beat with frame_start set and wrap at image_width (0 acts as 1, values above 4096 act as
// 4096). On beats without chroma, cb and cr read 128. Write configuration only while idle.
module rgb_to_yuv420_converter (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   input  logic [23:0]                    req_tdata,   // red, green, blue
   input  logic                           req_tuser,   // frame_start
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   output logic [23:0]                    rsp_tdata,   // luma, cb, cr
   output logic                           rsp_tuser,   // chroma_valid
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [ryuv_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [ryuv_pkg::WIDTH_W-1:0]   csr_data
);
   import ryuv_pkg::*;

   cfg_type    cfg;
   pixel_type  req_pixel;
   stage_type  mid_stage;
   logic       mid_valid;
   logic       mid_ready;
   logic [7:0] luma;
   logic [7:0] cb;
   logic [7:0] cr;

   assign req_pixel.red   = req_tdata[7:0];
   assign req_pixel.green = req_tdata[15:8];
   assign req_pixel.blue  = req_tdata[23:16];

   ryuv_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   ryuv_in_stage u_in_stage (
      .clock          (clock),
      .reset          (reset),
      .image_width    (cfg.image_width),
      .in_valid       (req_tvalid),
      .in_ready       (req_tready),
      .in_pixel       (req_pixel),
      .in_frame_start (req_tuser),
      .out_valid      (mid_valid),
      .out_ready      (mid_ready),
      .out_stage      (mid_stage)
   );

   ryuv_matrix_stage u_matrix_stage (
      .clock            (clock),
      .reset            (reset),
      .cfg              (cfg),
      .in_valid         (mid_valid),
      .in_ready         (mid_ready),
      .in_stage         (mid_stage),
      .out_valid        (rsp_tvalid),
      .out_ready        (rsp_tready),
      .out_luma         (luma),
      .out_cb           (cb),
      .out_cr           (cr),
      .out_chroma_valid (rsp_tuser)
   );

   assign rsp_tdata = {cr, cb, luma};

endmodule
